// ===== sv/fsat_pkg.sv =====
// Shared types and constants for the fragment send/ack tracker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fsat_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 1024;
  localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);

  localparam int ID_W   = 31;
  localparam int LEN_W  = 17;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int TICK_W = 3;
  localparam int OP_W   = 2;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 3'd3;
  localparam logic [TICK_W-1:0] TICK_MAX    = 3'd7;

  typedef enum logic [OP_W-1:0] {
    OP_NEW  = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // One burst of send records: every set bit of mask is one block to send.
  typedef struct packed {
    logic [MAX_BLOCKS-1:0] mask;
    logic [ID_W-1:0]       frame_id;
    logic [LEN_W-1:0]      length;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/fsat_front.sv =====
// Front end: takes events, keeps frame/pending/tick state, issues send bursts.
// Depends on fsat_pkg.
`timescale 1ns / 1ps

module fsat_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fsat_pkg::TICK_W-1:0]   cfg_wdata,
  input  logic                          acc,
  input  logic [fsat_pkg::OP_W-1:0]     op,
  input  logic [fsat_pkg::LEN_W-1:0]    frame_length,
  input  logic [fsat_pkg::ID_W-1:0]     ack_frame_id,
  input  logic [fsat_pkg::IDX_W-1:0]    ack_block,
  output logic                          push,
  output fsat_pkg::cmd_t                cmd
);

  logic [fsat_pkg::MAX_BLOCKS-1:0] pend_r, pend_nxt, clr_mask, start_mask;
  logic [fsat_pkg::CNT_W-1:0]      bcnt_r, bcnt_nxt, blocks;
  logic [fsat_pkg::ID_W-1:0]       sid_r, sid_nxt, nid_r, nid_nxt;
  logic [fsat_pkg::LEN_W-1:0]      slen_r, slen_nxt, wlen_r, wlen_nxt;
  logic                            wait_r, wait_nxt;
  logic [fsat_pkg::TICK_W-1:0]     tick_r, tick_nxt, tmo_r;
  logic [fsat_pkg::LEN_W:0]        len_round;
  logic [fsat_pkg::LEN_W-fsat_pkg::BLK_SHIFT:0] blocks_raw;
  logic                            start_chk, emit;

  // Block count of the waiting frame, rounded up and capped.
  assign len_round  = {1'b0, wlen_nxt} + (fsat_pkg::LEN_W+1)'(fsat_pkg::BLOCK_BYTES - 1);
  assign blocks_raw = len_round[fsat_pkg::LEN_W:fsat_pkg::BLK_SHIFT];

  always_comb begin
    if (blocks_raw > (fsat_pkg::LEN_W-fsat_pkg::BLK_SHIFT+1)'(fsat_pkg::MAX_BLOCKS))
      blocks = fsat_pkg::CNT_W'(fsat_pkg::MAX_BLOCKS);
    else
      blocks = fsat_pkg::CNT_W'(blocks_raw);
    for (int i = 0; i < fsat_pkg::MAX_BLOCKS; i++) begin
      start_mask[i] = (fsat_pkg::CNT_W'(i) < blocks);
      clr_mask[i]   = (ack_block == fsat_pkg::IDX_W'(i));
    end
  end

  always_comb begin
    pend_nxt  = pend_r;
    bcnt_nxt  = bcnt_r;
    sid_nxt   = sid_r;
    slen_nxt  = slen_r;
    nid_nxt   = nid_r;
    wlen_nxt  = wlen_r;
    wait_nxt  = wait_r;
    tick_nxt  = tick_r;
    start_chk = 1'b0;
    emit      = 1'b0;
    unique case (fsat_pkg::op_t'(op))
      fsat_pkg::OP_NEW: begin
        wlen_nxt  = frame_length;
        nid_nxt   = nid_r + 1'b1;
        wait_nxt  = 1'b1;
        start_chk = 1'b1;
      end
      fsat_pkg::OP_ACK: begin
        if (ack_frame_id == sid_r && {1'b0, ack_block} < bcnt_r) begin
          pend_nxt  = pend_r & ~clr_mask;
          start_chk = 1'b1;
        end
      end
      fsat_pkg::OP_TICK: begin
        if (tick_r != fsat_pkg::TICK_MAX) tick_nxt = tick_r + 1'b1;
        if (tick_nxt > tmo_r) begin
          pend_nxt  = '0;
          start_chk = 1'b1;
        end else if (!tick_nxt[0]) begin
          emit = 1'b1;
        end
      end
      default: ;
    endcase
    // A waiting frame takes over once nothing of the current one is pending.
    if (start_chk && pend_nxt == '0 && wait_nxt) begin
      sid_nxt  = nid_nxt;
      slen_nxt = wlen_nxt;
      bcnt_nxt = blocks;
      pend_nxt = start_mask;
      wait_nxt = 1'b0;
      tick_nxt = '0;
      emit     = 1'b1;
    end
  end

  assign push          = acc && emit && (pend_nxt != '0);
  assign cmd.mask      = pend_nxt;
  assign cmd.frame_id  = sid_nxt;
  assign cmd.length    = slen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      bcnt_r <= '0;
      sid_r  <= '0;
      slen_r <= '0;
      nid_r  <= '1;
      wait_r <= 1'b0;
      wlen_r <= '0;
      tick_r <= '0;
      tmo_r  <= fsat_pkg::TIMEOUT_RST;
    end else begin
      if (cfg_we) tmo_r <= cfg_wdata;
      if (acc) begin
        pend_r <= pend_nxt;
        bcnt_r <= bcnt_nxt;
        sid_r  <= sid_nxt;
        slen_r <= slen_nxt;
        nid_r  <= nid_nxt;
        wait_r <= wait_nxt;
        wlen_r <= wlen_nxt;
        tick_r <= tick_nxt;
      end
    end
  end

endmodule

// ===== sv/fsat_queue.sv =====
// Two-entry burst queue between front end and record scanner.
// Depends on fsat_pkg.
`timescale 1ns / 1ps

module fsat_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fsat_pkg::cmd_t     wdata,
  input  logic               pop,
  output fsat_pkg::cmd_t     rdata,
  output fsat_pkg::q_stat_t stat
);

  fsat_pkg::cmd_t ent_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rdata      = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop)) else $error("burst queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("burst queue underflow");

endmodule

// ===== sv/fsat_back.sv =====
// Back end: walks one burst mask a bit per cycle while the output is not stalled, one send record per set bit.
// Depends on fsat_pkg.
`timescale 1ns / 1ps

module fsat_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fsat_pkg::cmd_t              head,
  input  fsat_pkg::q_stat_t           q_stat,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [55:0]                 out_tdata,
  output logic                        out_tlast
);

  logic [fsat_pkg::MAX_BLOCKS-1:0] mask_r, mask_nxt;
  logic [fsat_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [fsat_pkg::ID_W-1:0]       fid_r;
  logic [fsat_pkg::LEN_W-1:0]      len_r;
  logic                            busy;

  assign busy       = (mask_r != '0);
  assign pop        = !busy && !q_stat.empty;
  assign out_tvalid = mask_r[0];
  assign out_tlast  = (mask_r[fsat_pkg::MAX_BLOCKS-1:1] == '0);
  assign out_tdata  = {2'b00, len_r, idx_r, fid_r};

  always_comb begin
    mask_nxt = mask_r;
    idx_nxt  = idx_r;
    if (pop) begin
      mask_nxt = head.mask;
      idx_nxt  = '0;
    end else if (busy && (!mask_r[0] || out_tready)) begin
      mask_nxt = mask_r >> 1;
      idx_nxt  = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fid_r <= head.frame_id;
      len_r <= head.length;
    end
    idx_r <= idx_nxt;
    if (!rst_n) mask_r <= '0;
    else        mask_r <= mask_nxt;
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(idx_r))
    else $error("record changed while stalled");
  a_burst_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> busy) else $error("empty burst loaded");

endmodule

// ===== sv/fragment_send_ack_tracker_core.sv =====
// Top level of the fragment send/ack tracker (selective-repeat sender).
// Depends on fsat_pkg, fsat_front, fsat_queue, fsat_back.
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_tvalid/in_tready | tuser: op; tdata: length, ack id, ack block
//   out_    | out | out_tvalid/tready   | tdata: frame id, block, length; tlast
//   cfg_    | in  | cfg_we              | cfg_wdata: timeout_ticks
//
// An event is taken whenever the burst queue has room.
// Each send burst is loaded by the bit-serial scanner in fsat_back, then
// scanned one block bit per cycle while the output is not stalled.
// Output stalls hold the scanner; the front keeps taking events until the
// two-entry queue fills. Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps

module fragment_send_ack_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,   // timeout_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // op
  input  logic [55:0] in_tdata,    // frame_length[16:0], ack_frame_id[47:17], ack_block[53:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // frame_id[30:0], block_index[36:31], total_length[53:37]
  output logic        out_tlast    // last record of this event
);

  logic              acc, push, pop;
  fsat_pkg::cmd_t    cmd, head;
  fsat_pkg::q_stat_t q_stat;

  // Every event may issue one burst, so it needs a free queue slot.
  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;

  fsat_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .acc          (acc),
    .op           (in_tuser),
    .frame_length (in_tdata[16:0]),
    .ack_frame_id (in_tdata[47:17]),
    .ack_block    (in_tdata[53:48]),
    .push         (push),
    .cmd          (cmd)
  );

  fsat_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd),
    .pop   (pop),
    .rdata (head),
    .stat  (q_stat)
  );

  fsat_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
